@@ hdl/vspc_pkg.sv @@
// shared types, constants and helper functions of the version string parser
`timescale 1ns / 1ps

package vspc_pkg;

    localparam int unsigned CharW   = 8;
    localparam int unsigned WordW   = 16;
    localparam int unsigned VerW    = 4 * WordW;
    localparam int unsigned OrderW  = 2;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned QDepth  = 4;
    localparam int unsigned QPtrW   = $clog2(QDepth);
    localparam int unsigned QCntW   = $clog2(QDepth + 1);
    localparam int unsigned OutDataW = 72;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_CURRENT  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_RELEASED = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_ALPHA    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_BETA     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_DEV      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RC       = 3'd5;

    // order codes
    localparam logic [OrderW-1:0] ORD_OLDER = 2'd0;
    localparam logic [OrderW-1:0] ORD_EQUAL = 2'd1;
    localparam logic [OrderW-1:0] ORD_NEWER = 2'd2;

    // tag selects
    localparam logic [1:0] TAG_ALPHA = 2'd0;
    localparam logic [1:0] TAG_BETA  = 2'd1;
    localparam logic [1:0] TAG_DEV   = 2'd2;
    localparam logic [1:0] TAG_RC    = 2'd3;

    // characters
    localparam logic [CharW-1:0] CH_NUL  = 8'h00;
    localparam logic [CharW-1:0] CH_TAB  = 8'h09;
    localparam logic [CharW-1:0] CH_LF   = 8'h0A;
    localparam logic [CharW-1:0] CH_CR   = 8'h0D;
    localparam logic [CharW-1:0] CH_SP   = 8'h20;
    localparam logic [CharW-1:0] CH_DASH = 8'h2D;
    localparam logic [CharW-1:0] CH_DOT  = 8'h2E;
    localparam logic [CharW-1:0] CH_0    = 8'h30;
    localparam logic [CharW-1:0] CH_9    = 8'h39;
    localparam logic [CharW-1:0] CH_A    = 8'h41;
    localparam logic [CharW-1:0] CH_B    = 8'h42;
    localparam logic [CharW-1:0] CH_C    = 8'h43;
    localparam logic [CharW-1:0] CH_D    = 8'h44;
    localparam logic [CharW-1:0] CH_E    = 8'h45;
    localparam logic [CharW-1:0] CH_H    = 8'h48;
    localparam logic [CharW-1:0] CH_L    = 8'h4C;
    localparam logic [CharW-1:0] CH_P    = 8'h50;
    localparam logic [CharW-1:0] CH_R    = 8'h52;
    localparam logic [CharW-1:0] CH_T    = 8'h54;
    localparam logic [CharW-1:0] CH_V    = 8'h56;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_MAJOR,
        PH_MINOR,
        PH_REV,
        PH_SKIP,
        PH_TAGSEL,
        PH_TAGLET,
        PH_TAGNUM
    } t_phase;

    // one decided string, as handed from parser to comparator
    typedef struct packed {
        logic             ok;
        logic [WordW-1:0] major;
        logic [WordW-1:0] minor;
        logic [WordW-1:0] revision;
        logic [WordW-1:0] flavor;
    } t_result;

    typedef struct packed {
        logic [WordW-1:0] released;
        logic [WordW-1:0] alpha;
        logic [WordW-1:0] beta;
        logic [WordW-1:0] dev;
        logic [WordW-1:0] rc;
    } t_masks;

    // expected letter of a tag at a position, zero past its end
    function automatic logic [CharW-1:0] tag_char(input logic [1:0] sel,
                                                  input logic [2:0] pos);
        logic [CharW-1:0] ch;
        ch = CH_NUL;
        case (sel)
            TAG_ALPHA: begin
                case (pos)
                    3'd0: ch = CH_A;
                    3'd1: ch = CH_L;
                    3'd2: ch = CH_P;
                    3'd3: ch = CH_H;
                    3'd4: ch = CH_A;
                    default: ch = CH_NUL;
                endcase
            end
            TAG_BETA: begin
                case (pos)
                    3'd0: ch = CH_B;
                    3'd1: ch = CH_E;
                    3'd2: ch = CH_T;
                    3'd3: ch = CH_A;
                    default: ch = CH_NUL;
                endcase
            end
            TAG_DEV: begin
                case (pos)
                    3'd0: ch = CH_D;
                    3'd1: ch = CH_E;
                    3'd2: ch = CH_V;
                    default: ch = CH_NUL;
                endcase
            end
            default: begin
                case (pos)
                    3'd0: ch = CH_R;
                    3'd1: ch = CH_C;
                    default: ch = CH_NUL;
                endcase
            end
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] tag_len(input logic [1:0] sel);
        logic [2:0] len;
        case (sel)
            TAG_ALPHA: len = 3'd5;
            TAG_BETA:  len = 3'd4;
            TAG_DEV:   len = 3'd3;
            default:   len = 3'd2;
        endcase
        return len;
    endfunction

endpackage

@@ hdl/vspc_front.sv @@
// character parser: walks the version grammar and emits one decision per string
`timescale 1ns / 1ps

module vspc_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [vspc_pkg::CharW-1:0]        i_char,
    input  logic                              i_first,
    input  vspc_pkg::t_masks                  i_masks,
    input  logic                              i_q_full,
    output logic                              o_push,
    output vspc_pkg::t_result                 o_result
);

    vspc_pkg::t_phase             r_phase, n_phase, e_phase;
    logic [vspc_pkg::WordW-1:0]   r_acc, n_acc, e_acc;
    logic [vspc_pkg::WordW-1:0]   r_major, n_major, e_major;
    logic [vspc_pkg::WordW-1:0]   r_minor, n_minor, e_minor;
    logic [vspc_pkg::WordW-1:0]   r_rev, n_rev, e_rev;
    logic [1:0]                   r_sel, n_sel, e_sel;
    logic [2:0]                   r_pos, n_pos, e_pos;

    logic                         accept;
    logic                         is_numeral;
    logic                         is_end;
    logic [vspc_pkg::WordW-1:0]   acc_step;
    logic [vspc_pkg::WordW-1:0]   tag_mask;
    logic                         emit;
    logic                         emit_ok;
    logic [vspc_pkg::WordW-1:0]   emit_flavor;
    logic [2:0]                   pos_inc;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;

    assign is_numeral = (i_char >= vspc_pkg::CH_0) && (i_char <= vspc_pkg::CH_9);
    assign is_end   = (i_char == vspc_pkg::CH_NUL) || (i_char == vspc_pkg::CH_SP)
                   || (i_char == vspc_pkg::CH_TAB) || (i_char == vspc_pkg::CH_LF)
                   || (i_char == vspc_pkg::CH_CR);

    // first character restarts with cleared state
    always_comb begin
        if (i_first) begin
            e_phase = vspc_pkg::PH_MAJOR;
            e_acc   = '0;
            e_major = '0;
            e_minor = '0;
            e_rev   = '0;
            e_sel   = '0;
            e_pos   = '0;
        end else begin
            e_phase = r_phase;
            e_acc   = r_acc;
            e_major = r_major;
            e_minor = r_minor;
            e_rev   = r_rev;
            e_sel   = r_sel;
            e_pos   = r_pos;
        end
    end

    // acc * 10 + digit, wraps at 16 bits
    assign acc_step = (e_acc << 3) + (e_acc << 1)
                    + {{(vspc_pkg::WordW - 4){1'b0}}, i_char[3:0]};

    always_comb begin
        case (e_sel)
            vspc_pkg::TAG_ALPHA: tag_mask = i_masks.alpha;
            vspc_pkg::TAG_BETA:  tag_mask = i_masks.beta;
            vspc_pkg::TAG_DEV:   tag_mask = i_masks.dev;
            default:             tag_mask = i_masks.rc;
        endcase
    end

    assign pos_inc = e_pos + 3'd1;

    always_comb begin
        n_phase     = e_phase;
        n_acc       = e_acc;
        n_major     = e_major;
        n_minor     = e_minor;
        n_rev       = e_rev;
        n_sel       = e_sel;
        n_pos       = e_pos;
        emit        = 1'b0;
        emit_ok     = 1'b0;
        emit_flavor = '0;
        case (e_phase)
            vspc_pkg::PH_MAJOR, vspc_pkg::PH_MINOR: begin
                if (is_numeral) begin
                    n_acc = acc_step;
                end else if (i_char != vspc_pkg::CH_DOT) begin
                    emit = 1'b1;
                end else begin
                    if (e_phase == vspc_pkg::PH_MAJOR) begin
                        n_major = e_acc;
                        n_phase = vspc_pkg::PH_MINOR;
                    end else begin
                        n_minor = e_acc;
                        n_phase = vspc_pkg::PH_REV;
                    end
                    n_acc = '0;
                end
            end
            vspc_pkg::PH_REV: begin
                if (is_numeral) begin
                    n_acc = acc_step;
                end else begin
                    n_rev   = e_acc;
                    n_acc   = '0;
                    n_phase = vspc_pkg::PH_SKIP;
                    if (is_end) begin
                        emit        = 1'b1;
                        emit_ok     = 1'b1;
                        emit_flavor = i_masks.released;
                    end else if (i_char == vspc_pkg::CH_DASH) begin
                        n_phase = vspc_pkg::PH_TAGSEL;
                    end
                end
            end
            vspc_pkg::PH_SKIP: begin
                if (is_end) begin
                    emit        = 1'b1;
                    emit_ok     = 1'b1;
                    emit_flavor = i_masks.released;
                end else if (i_char == vspc_pkg::CH_DASH) begin
                    n_phase = vspc_pkg::PH_TAGSEL;
                end
            end
            vspc_pkg::PH_TAGSEL: begin
                n_pos   = 3'd1;
                n_phase = vspc_pkg::PH_TAGLET;
                if (i_char == vspc_pkg::CH_A) begin
                    n_sel = vspc_pkg::TAG_ALPHA;
                end else if (i_char == vspc_pkg::CH_B) begin
                    n_sel = vspc_pkg::TAG_BETA;
                end else if (i_char == vspc_pkg::CH_D) begin
                    n_sel = vspc_pkg::TAG_DEV;
                end else if (i_char == vspc_pkg::CH_R) begin
                    n_sel = vspc_pkg::TAG_RC;
                end else begin
                    emit = 1'b1;
                end
            end
            vspc_pkg::PH_TAGLET: begin
                if ((e_pos >= 3'd5) || (i_char != vspc_pkg::tag_char(e_sel, e_pos))) begin
                    emit = 1'b1;
                end else begin
                    n_pos = pos_inc;
                    if (pos_inc >= vspc_pkg::tag_len(e_sel)) begin
                        n_acc   = '0;
                        n_phase = vspc_pkg::PH_TAGNUM;
                    end
                end
            end
            vspc_pkg::PH_TAGNUM: begin
                if (is_numeral) begin
                    n_acc = acc_step;
                end else begin
                    emit        = 1'b1;
                    emit_ok     = 1'b1;
                    emit_flavor = e_acc | tag_mask;
                end
            end
            default: begin
                // decided or never started: characters are dropped
                n_phase = e_phase;
            end
        endcase
        if (emit) begin
            n_phase = vspc_pkg::PH_IDLE;
        end
    end

    always_comb begin
        o_push = accept && emit;
        if (emit_ok) begin
            o_result.ok       = 1'b1;
            o_result.major    = n_major;
            o_result.minor    = n_minor;
            o_result.revision = n_rev;
            o_result.flavor   = emit_flavor;
        end else begin
            o_result = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vspc_pkg::PH_IDLE;
            r_acc   <= '0;
            r_major <= '0;
            r_minor <= '0;
            r_rev   <= '0;
            r_sel   <= '0;
            r_pos   <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_major <= n_major;
            r_minor <= n_minor;
            r_rev   <= n_rev;
            r_sel   <= n_sel;
            r_pos   <= n_pos;
        end
    end

endmodule

@@ hdl/vspc_queue.sv @@
// short queue of decided strings between parser and comparator
`timescale 1ns / 1ps

module vspc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  vspc_pkg::t_result i_data,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output vspc_pkg::t_result o_data
);

    vspc_pkg::t_result               r_mem [vspc_pkg::QDepth];
    logic [vspc_pkg::QPtrW-1:0]      r_wr_ptr;
    logic [vspc_pkg::QPtrW-1:0]      r_rd_ptr;
    logic [vspc_pkg::QCntW-1:0]      r_count;
    logic                            do_push;
    logic                            do_pop;

    assign o_full  = (r_count == vspc_pkg::QCntW'(vspc_pkg::QDepth));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/vspc_back.sv @@
// comparator and output register: orders a decided version against the current one
`timescale 1ns / 1ps

module vspc_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  vspc_pkg::t_result                  i_result,
    output logic                               o_pop,
    input  logic [vspc_pkg::VerW-1:0]          i_current,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [vspc_pkg::OutDataW-1:0]      o_data
);

    logic                              r_valid;
    logic [vspc_pkg::OutDataW-1:0]     r_data;
    logic [vspc_pkg::VerW-1:0]         mine;
    logic [vspc_pkg::OrderW-1:0]       order;
    logic [vspc_pkg::OutDataW-1:0]     n_data;

    assign o_pop = i_valid && (!r_valid || i_ready);

    // word-wise lexicographic order equals an unsigned compare of the packed words
    assign mine = {i_result.major, i_result.minor, i_result.revision, i_result.flavor};

    always_comb begin
        if (!i_result.ok) begin
            order = vspc_pkg::ORD_OLDER;
        end else if (mine > i_current) begin
            order = vspc_pkg::ORD_NEWER;
        end else if (mine == i_current) begin
            order = vspc_pkg::ORD_EQUAL;
        end else begin
            order = vspc_pkg::ORD_OLDER;
        end
    end

    assign n_data = {{(vspc_pkg::OutDataW - 1 - vspc_pkg::VerW - vspc_pkg::OrderW){1'b0}},
                     order, i_result.flavor, i_result.revision, i_result.minor,
                     i_result.major, i_result.ok};

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ hdl/version_string_parse_compare_unit.sv @@
// top level of the version string parser and comparator
//
// input stream: one character per beat in s_axis_tdata, s_axis_tuser set on the
// first character of a string; a new first character drops any open string
// output stream: one beat per string at the character that decides it, carrying
// ok, the four version words and the order against the current version
// config channel: register index and data, always ready; write only while idle
// throughput: one character per cycle, sustained; the parser takes a beat in
// every cycle in which the four-entry result queue is not full
// path: a result is written into a queue entry at its deciding character, then held
// in the comparator output register, which drives m_axis
// stall: while m_axis_tready is low the output register holds its beat, the
// queue fills behind it, and s_axis_tready drops only once the queue is full
// reset: synchronous, active low; parser idle with no string open, queue and
// output empty, registers back to their defaults
`timescale 1ns / 1ps

module version_string_parse_compare_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [vspc_pkg::CharW-1:0]         s_axis_tdata,  // [7:0] char_code
    input  logic                               s_axis_tuser,  // [0] first_char
    // output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] ok, [16:1] major_word, [32:17] minor_word, [48:33] revision_word,
    // [64:49] flavor_word, [66:65] order, [71:67] zero
    output logic [vspc_pkg::OutDataW-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [vspc_pkg::CfgIdxW-1:0]       i_cfg_index,
    input  logic [vspc_pkg::VerW-1:0]          i_cfg_data
);

    logic [vspc_pkg::VerW-1:0]  r_current;
    vspc_pkg::t_masks           r_masks;
    logic                       cfg_we;

    logic                       q_full;
    logic                       q_push;
    vspc_pkg::t_result          q_in;
    logic                       q_valid;
    logic                       q_pop;
    vspc_pkg::t_result          q_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;

    // config register file, indexes past the last register are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_current        <= '0;
            r_masks.released <= 16'd128;
            r_masks.alpha    <= 16'd16;
            r_masks.beta     <= 16'd32;
            r_masks.dev      <= 16'd0;
            r_masks.rc       <= 16'd64;
        end else if (cfg_we) begin
            case (i_cfg_index)
                vspc_pkg::REG_CURRENT:  r_current        <= i_cfg_data;
                vspc_pkg::REG_RELEASED: r_masks.released <= i_cfg_data[vspc_pkg::WordW-1:0];
                vspc_pkg::REG_ALPHA:    r_masks.alpha    <= i_cfg_data[vspc_pkg::WordW-1:0];
                vspc_pkg::REG_BETA:     r_masks.beta     <= i_cfg_data[vspc_pkg::WordW-1:0];
                vspc_pkg::REG_DEV:      r_masks.dev      <= i_cfg_data[vspc_pkg::WordW-1:0];
                vspc_pkg::REG_RC:       r_masks.rc       <= i_cfg_data[vspc_pkg::WordW-1:0];
                default: begin
                    r_current <= r_current;
                end
            endcase
        end
    end

    // front: grammar walk, one character per beat
    vspc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_char   (s_axis_tdata),
        .i_first  (s_axis_tuser),
        .i_masks  (r_masks),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_result (q_in)
    );

    // decoupling queue
    vspc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_out)
    );

    // back: compare and hold the output beat
    vspc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (q_valid),
        .i_result  (q_out),
        .o_pop     (q_pop),
        .i_current (r_current),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata)
    );

endmodule
